[rtl/rlnv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlnv_pkg: shared types and constants of the RC ramp / LFSR noise voice
// Widths, Q16 rate reciprocals, sequencer codes and divider handshake types.
// ----------------------------------------------------------------------------
package rlnv_pkg;

    // noise table geometry
    localparam int NOISE_BITS = 18;
    localparam int OFFSET_W   = NOISE_BITS;
    localparam int WORD_W     = 32;
    localparam int BIT_SEL_W  = $clog2(WORD_W);
    localparam int TBL_ADDR_W = NOISE_BITS - BIT_SEL_W;

    // channel payloads
    localparam int CTL_W   = 2;
    localparam int LEVEL_W = 15;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd32767;

    // counters and rates
    localparam int CTR_W  = 24;
    localparam int DEF_W  = 22;
    localparam int SR_W   = 18;
    localparam logic [SR_W-1:0] SR_RESET = 18'd44100;

    localparam int RECIP_W = 23;
    localparam logic [RECIP_W-1:0] RECIP_C1_DIS = 23'd481882;
    localparam logic [RECIP_W-1:0] RECIP_CHARGE = 23'd7246351;
    localparam logic [RECIP_W-1:0] RECIP_C2_DIS = 23'd205056;
    localparam int RECIP_SHIFT = 16;

    localparam int PROD_W = LEVEL_W + RECIP_W;
    localparam int FREQ_SCALE_W = 13;
    localparam logic [FREQ_SCALE_W-1:0] FREQ_SCALE = 13'd6325;
    localparam logic [DEF_W-1:0] FREQ_BASE   = 22'd588;
    localparam int FREQ_SHIFT = 15;
    localparam logic [DEF_W-1:0] FILTER_RATE = 22'd400;

    // radix-4 divider: two quotient bits per cycle
    localparam int DIV_STEPS = DEF_W / 2;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_SUB,
        ST_DIV,
        ST_APPLY,
        ST_TBL,
        ST_OUT
    } t_state;

    // counter memory entries, processed in this order
    typedef enum logic [1:0] {
        SLOT_CAP1,
        SLOT_CAP2,
        SLOT_NOISE,
        SLOT_FILT
    } t_slot;

    localparam int SLOT_NUM = 4;

    typedef struct packed {
        logic             start;
        logic [DEF_W-1:0] dividend;
        logic [SR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DEF_W-1:0] quot;
        logic [SR_W-1:0]  rem;
    } t_div_rsp;

endpackage
`default_nettype wire

[rtl/rlnv_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlnv_if: valid/ready channels of the noise voice
// Input channel carries the control bits, output channel the sample word.
// ----------------------------------------------------------------------------
interface rlnv_in_if;
    logic                       valid;
    logic                       ready;
    logic [rlnv_pkg::CTL_W-1:0] control_bits;

    modport source (output valid, output control_bits, input ready);
    modport sink   (input valid, input control_bits, output ready);
endinterface

interface rlnv_out_if;
    logic                         valid;
    logic                         ready;
    logic [rlnv_pkg::LEVEL_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

[rtl/rlnv_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlnv_div: multi-cycle unsigned divider for counter refills
// Restoring division, two quotient bits per cycle; quotient and remainder
// stay valid after the done pulse until the next start.
// ----------------------------------------------------------------------------
module rlnv_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rlnv_pkg::t_div_req  i_req,
    output rlnv_pkg::t_div_rsp  o_rsp
);

    localparam int DEF_W = rlnv_pkg::DEF_W;
    localparam int SR_W  = rlnv_pkg::SR_W;
    localparam int CNT_W = $clog2(rlnv_pkg::DIV_STEPS + 1);

    logic [DEF_W-1:0] r_quo, n_quo;
    logic [SR_W-1:0]  r_rem, n_rem;
    logic [SR_W-1:0]  r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // two shift/compare/subtract steps
    always_comb begin
        logic [SR_W:0] part;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            part  = {n_rem, n_quo[DEF_W-1]};
            n_quo = {n_quo[DEF_W-2:0], 1'b0};
            if (part >= {1'b0, r_dsr}) begin
                part     = part - {1'b0, r_dsr};
                n_quo[0] = 1'b1;
            end
            n_rem = part[SR_W-1:0];
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(rlnv_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

[rtl/rlnv_tbl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlnv_tbl: LFSR noise bit table
// After reset it fills itself with the XNOR LFSR sequence from a zero seed,
// eight shifts per cycle, then serves one registered word read per cycle.
// ----------------------------------------------------------------------------
module rlnv_tbl (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [rlnv_pkg::TBL_ADDR_W-1:0]    i_rd_addr,
    output logic [rlnv_pkg::WORD_W-1:0]        o_rd_data,
    output logic                               o_ready
);

    localparam int NB        = rlnv_pkg::NOISE_BITS;
    localparam int WORD_W    = rlnv_pkg::WORD_W;
    localparam int ADDR_W    = rlnv_pkg::TBL_ADDR_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int FILL_BITS = 8;
    localparam int CHUNKS    = WORD_W / FILL_BITS;
    localparam int SUB_W     = $clog2(CHUNKS);

    logic [WORD_W-1:0] r_tbl_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    logic [NB-1:0]     r_lfsr, n_lfsr;
    logic [WORD_W-1:0] r_word, n_word;
    logic [ADDR_W-1:0] r_addr;
    logic [SUB_W-1:0]  r_sub;
    logic              r_busy;
    logic              fill_we;

    // eight LFSR shifts, output bit enters the word from the top
    always_comb begin
        n_lfsr = r_lfsr;
        n_word = r_word;
        for (int k = 0; k < FILL_BITS; k++) begin
            n_word = {n_lfsr[0], n_word[WORD_W-1:1]};
            n_lfsr = {n_lfsr[NB-2:0], ~(n_lfsr[NB-2] ^ n_lfsr[NB-1])};
        end
    end

    assign fill_we = r_busy && (r_sub == SUB_W'(CHUNKS - 1));

    // fill sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_lfsr <= '0;
            r_addr <= '0;
            r_sub  <= '0;
        end else if (r_busy) begin
            r_lfsr <= n_lfsr;
            r_sub  <= fill_we ? '0 : r_sub + SUB_W'(1);
            if (fill_we) begin
                r_addr <= r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(DEPTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_tbl_mem[r_addr] <= n_word;
        end
        r_rd_data <= r_tbl_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_busy;

endmodule
`default_nettype wire

[rtl/rc_ramp_lfsr_noise_voice_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_ramp_lfsr_noise_voice_top: two-capacitor ramp noise voice
// One control word in per sample tick, one sample word out. Ramp, noise
// clock and 400 Hz resample counters live in a small counter memory and are
// updated read-modify-write by a sequencer.
//
//   channel   dir  payload               handshake
//   i_in      in   control_bits [1:0]    valid/ready
//   o_out     out  sample [14:0]         valid/ready
//   i_cfg_*   in   tick_rate [17:0]      write enable, no wait
//
// Sequence: per word, each counter passes a prep, read and subtract state,
//   then the word takes one output state and the idle state. Each underflow
//   adds a wait in the radix-4 refill divider and a write-back, plus a noise
//   table read for the noise counter. The worst case is set by the four
//   serial refill divisions.
// Reset: table fill of 8192 words, each packed from four LFSR chunks,
//   with input ready low; configuration writes are taken throughout.
// Stalls: a finished sample waits in the output register while the next
//   word is accepted; a second sample waits in the last state.
// ----------------------------------------------------------------------------
module rc_ramp_lfsr_noise_voice_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    rlnv_in_if.sink                      i_in,
    rlnv_out_if.source                   o_out,
    input  wire                          i_cfg_wr_en,
    input  wire  [rlnv_pkg::SR_W-1:0]    i_cfg_wr_data
);

    localparam int LEVEL_W  = rlnv_pkg::LEVEL_W;
    localparam int CTR_W    = rlnv_pkg::CTR_W;
    localparam int DEF_W    = rlnv_pkg::DEF_W;
    localparam int SR_W     = rlnv_pkg::SR_W;
    localparam int PROD_W   = rlnv_pkg::PROD_W;
    localparam int OFFSET_W = rlnv_pkg::OFFSET_W;
    localparam int WORD_W   = rlnv_pkg::WORD_W;
    localparam int BSEL_W   = rlnv_pkg::BIT_SEL_W;
    localparam int N_W      = DEF_W + 1;

    // control and state registers
    rlnv_pkg::t_state r_state, n_state;
    rlnv_pkg::t_slot  r_slot, n_slot;
    logic [SR_W-1:0]     r_sr;
    logic [LEVEL_W-1:0]  r_lvl1, n_lvl1;
    logic [LEVEL_W-1:0]  r_lvl2, n_lvl2;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic                r_noise_bit, n_noise_bit;
    logic                r_filt_bit, n_filt_bit;
    logic                r_out_valid, n_out_valid;

    // payload registers
    logic [rlnv_pkg::CTL_W-1:0] r_ctl;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [DEF_W-1:0]    r_dec, n_dec;
    logic                r_skip, n_skip;
    logic [LEVEL_W-1:0]  r_out_sample, n_out_sample;

    // counter memory
    logic [CTR_W-1:0]    r_ctr_mem [rlnv_pkg::SLOT_NUM];
    logic [rlnv_pkg::SLOT_NUM-1:0] r_ctr_vld;
    logic [CTR_W-1:0]    r_ctr_rdata;
    logic                r_ctr_rd_vld;
    logic                ctr_we;
    logic [CTR_W-1:0]    ctr_wdata;

    // datapath nets
    logic                in_acc;
    logic                cur_charge;
    logic [LEVEL_W-1:0]  cur_lvl;
    logic [rlnv_pkg::RECIP_W-1:0] cur_recip;
    logic [LEVEL_W-1:0]  span;
    logic [LEVEL_W-1:0]  room;
    logic [LEVEL_W-1:0]  v1, v2, avg;
    logic [LEVEL_W:0]    vsum;
    logic [LEVEL_W:0]    out_sum;
    logic signed [CTR_W-1:0] ctr_cur, ctr_new;
    logic [CTR_W-1:0]    ctr_neg;
    logic                ctr_pos;
    logic [SR_W-1:0]     eff_sr;
    logic [N_W-1:0]      n_steps;
    logic [LEVEL_W-1:0]  lvl_new;
    logic                slot_done;
    logic                out_load;

    // divider and table
    rlnv_pkg::t_div_req  div_req;
    rlnv_pkg::t_div_rsp  div_rsp;
    logic [WORD_W-1:0]   tbl_rdata;
    logic                tbl_ready;

    rlnv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rlnv_tbl u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (n_offset[OFFSET_W-1:BSEL_W]),
        .o_rd_data (tbl_rdata),
        .o_ready   (tbl_ready)
    );

    function automatic rlnv_pkg::t_slot next_slot(input rlnv_pkg::t_slot s);
        rlnv_pkg::t_slot r;
        case (s)
            rlnv_pkg::SLOT_CAP1:  r = rlnv_pkg::SLOT_CAP2;
            rlnv_pkg::SLOT_CAP2:  r = rlnv_pkg::SLOT_NOISE;
            rlnv_pkg::SLOT_NOISE: r = rlnv_pkg::SLOT_FILT;
            default:              r = rlnv_pkg::SLOT_CAP1;
        endcase
        return r;
    endfunction

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == rlnv_pkg::ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.sample = r_out_sample;

    // ramp and voltage terms
    always_comb begin
        if (r_slot == rlnv_pkg::SLOT_CAP2) begin
            cur_lvl    = r_lvl2;
            cur_charge = r_ctl[1];
            cur_recip  = r_ctl[1] ? rlnv_pkg::RECIP_CHARGE : rlnv_pkg::RECIP_C2_DIS;
        end else begin
            cur_lvl    = r_lvl1;
            cur_charge = !r_ctl[0];
            cur_recip  = r_ctl[0] ? rlnv_pkg::RECIP_C1_DIS : rlnv_pkg::RECIP_CHARGE;
        end
        room = rlnv_pkg::LEVEL_MAX - cur_lvl;
        span = cur_charge ? room : cur_lvl;
        v1   = rlnv_pkg::LEVEL_MAX - r_lvl1;
        v2   = r_lvl2;
        vsum = {1'b0, v1} + {1'b0, v2};
        avg  = vsum[LEVEL_W:1];
        out_sum = (r_noise_bit ? '0 : {1'b0, v1}) + (r_filt_bit ? '0 : {1'b0, v2});
    end

    // counter arithmetic
    always_comb begin
        eff_sr  = (r_sr == '0) ? SR_W'(1) : r_sr;
        ctr_cur = r_ctr_rd_vld ? $signed(r_ctr_rdata) : '0;
        ctr_new = ctr_cur - $signed({{(CTR_W - DEF_W){1'b0}}, r_dec});
        ctr_neg = -ctr_new;
        ctr_pos = !ctr_new[CTR_W-1] && (ctr_new != '0);
        n_steps = {1'b0, div_rsp.quot} + N_W'(1);
        if (cur_charge) begin
            lvl_new = (n_steps >= {{(N_W - LEVEL_W){1'b0}}, room}) ?
                      rlnv_pkg::LEVEL_MAX : cur_lvl + n_steps[LEVEL_W-1:0];
        end else begin
            lvl_new = (n_steps >= {{(N_W - LEVEL_W){1'b0}}, cur_lvl}) ?
                      '0 : cur_lvl - n_steps[LEVEL_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rlnv_pkg::ST_FILL: begin
                if (tbl_ready) n_state = rlnv_pkg::ST_IDLE;
            end
            rlnv_pkg::ST_IDLE: begin
                if (in_acc) n_state = rlnv_pkg::ST_PREP;
            end
            rlnv_pkg::ST_PREP: n_state = rlnv_pkg::ST_READ;
            rlnv_pkg::ST_READ: n_state = rlnv_pkg::ST_SUB;
            rlnv_pkg::ST_SUB: begin
                if (!r_skip && !ctr_pos) begin
                    n_state = rlnv_pkg::ST_DIV;
                end else if (r_slot == rlnv_pkg::SLOT_FILT) begin
                    n_state = rlnv_pkg::ST_OUT;
                end else begin
                    n_state = rlnv_pkg::ST_PREP;
                end
            end
            rlnv_pkg::ST_DIV: begin
                if (div_rsp.done) n_state = rlnv_pkg::ST_APPLY;
            end
            rlnv_pkg::ST_APPLY: begin
                if (r_slot == rlnv_pkg::SLOT_NOISE) begin
                    n_state = rlnv_pkg::ST_TBL;
                end else if (r_slot == rlnv_pkg::SLOT_FILT) begin
                    n_state = rlnv_pkg::ST_OUT;
                end else begin
                    n_state = rlnv_pkg::ST_PREP;
                end
            end
            rlnv_pkg::ST_TBL: n_state = rlnv_pkg::ST_PREP;
            rlnv_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) n_state = rlnv_pkg::ST_IDLE;
            end
            default: n_state = rlnv_pkg::ST_FILL;
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb begin
        n_slot       = r_slot;
        n_lvl1       = r_lvl1;
        n_lvl2       = r_lvl2;
        n_offset     = r_offset;
        n_noise_bit  = r_noise_bit;
        n_filt_bit   = r_filt_bit;
        n_prod       = r_prod;
        n_dec        = r_dec;
        n_skip       = r_skip;
        n_out_sample = r_out_sample;
        ctr_we       = 1'b0;
        ctr_wdata    = ctr_new;
        slot_done    = 1'b0;
        out_load     = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = ctr_neg[DEF_W-1:0];
        div_req.divisor  = eff_sr;

        case (r_state)
            rlnv_pkg::ST_IDLE: begin
                if (in_acc) n_slot = rlnv_pkg::SLOT_CAP1;
            end
            // one multiply per slot, registered
            rlnv_pkg::ST_PREP: begin
                if (r_slot == rlnv_pkg::SLOT_NOISE) begin
                    n_prod = {{(PROD_W - LEVEL_W){1'b0}}, avg} * rlnv_pkg::FREQ_SCALE;
                    n_skip = 1'b0;
                end else begin
                    n_prod = {{(PROD_W - LEVEL_W){1'b0}}, span} * cur_recip;
                    n_skip = (r_slot != rlnv_pkg::SLOT_FILT) && (span == '0);
                end
            end
            // counter read in flight; form the decrement
            rlnv_pkg::ST_READ: begin
                case (r_slot)
                    rlnv_pkg::SLOT_NOISE:
                        n_dec = rlnv_pkg::FREQ_BASE + r_prod[rlnv_pkg::FREQ_SHIFT +: DEF_W];
                    rlnv_pkg::SLOT_FILT:
                        n_dec = rlnv_pkg::FILTER_RATE;
                    default:
                        n_dec = r_prod[rlnv_pkg::RECIP_SHIFT +: DEF_W];
                endcase
            end
            // subtract; write back or start the refill division
            rlnv_pkg::ST_SUB: begin
                if (r_skip) begin
                    slot_done = 1'b1;
                end else if (ctr_pos) begin
                    ctr_we    = 1'b1;
                    slot_done = 1'b1;
                end else begin
                    div_req.start = 1'b1;
                end
            end
            // refill counter to rate - remainder, apply quotient + 1
            rlnv_pkg::ST_APPLY: begin
                ctr_we    = 1'b1;
                ctr_wdata = {{(CTR_W - SR_W){1'b0}}, eff_sr - div_rsp.rem};
                case (r_slot)
                    rlnv_pkg::SLOT_CAP1: begin
                        n_lvl1    = lvl_new;
                        slot_done = 1'b1;
                    end
                    rlnv_pkg::SLOT_CAP2: begin
                        n_lvl2    = lvl_new;
                        slot_done = 1'b1;
                    end
                    rlnv_pkg::SLOT_NOISE: begin
                        n_offset = r_offset + n_steps[OFFSET_W-1:0];
                    end
                    default: begin
                        n_filt_bit = r_noise_bit;
                        slot_done  = 1'b1;
                    end
                endcase
            end
            rlnv_pkg::ST_TBL: begin
                n_noise_bit = tbl_rdata[r_offset[BSEL_W-1:0]];
                slot_done   = 1'b1;
            end
            rlnv_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load     = 1'b1;
                    n_out_sample = out_sum[LEVEL_W:1];
                end
            end
            default: ;
        endcase

        if (slot_done) n_slot = next_slot(r_slot);
        n_out_valid = out_load || (r_out_valid && !o_out.ready);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlnv_pkg::ST_FILL;
            r_slot      <= rlnv_pkg::SLOT_CAP1;
            r_sr        <= rlnv_pkg::SR_RESET;
            r_lvl1      <= '0;
            r_lvl2      <= '0;
            r_offset    <= '0;
            r_noise_bit <= 1'b0;
            r_filt_bit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_lvl1      <= n_lvl1;
            r_lvl2      <= n_lvl2;
            r_offset    <= n_offset;
            r_noise_bit <= n_noise_bit;
            r_filt_bit  <= n_filt_bit;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) r_sr <= i_cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) r_ctl <= i_in.control_bits;
        r_prod       <= n_prod;
        r_dec        <= n_dec;
        r_skip       <= n_skip;
        r_out_sample <= n_out_sample;
    end

    // counter memory, registered read
    always_ff @(posedge i_clk) begin
        if (ctr_we) r_ctr_mem[r_slot] <= ctr_wdata;
        r_ctr_rdata <= r_ctr_mem[r_slot];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr_vld    <= '0;
            r_ctr_rd_vld <= 1'b0;
        end else begin
            if (ctr_we) r_ctr_vld[r_slot] <= 1'b1;
            r_ctr_rd_vld <= r_ctr_vld[r_slot];
        end
    end

endmodule
`default_nettype wire

[rtl/rlnv_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlnv_chk: port-level checks of the noise voice
// Tracks words in flight and checks reset, output hold, one-at-a-time
// acceptance, output words without input words and words in flight.
// ----------------------------------------------------------------------------
module rlnv_chk (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           i_in_ready,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire [rlnv_pkg::LEVEL_W-1:0]   i_out_sample
);

    logic [1:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample))
        else $error("stalled output word changed");

    // one word processed at a time
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("ready stayed high after accept");

    // every output word belongs to an accepted input word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("output word without input word");

    // at most one finished word waits while another is taken
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_pending != 2'd2 && r_pending != 2'd3)
        else $error("too many words in flight");

endmodule

bind rc_ramp_lfsr_noise_voice_top rlnv_chk u_rlnv_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample)
);
`default_nettype wire
